[sv/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the SPI master shift engine.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int unsigned NUM_SLOTS = 4;
   localparam int unsigned EFF_SLOTS = (NUM_SLOTS < 4) ? NUM_SLOTS : 4;

   localparam logic [15:0] CS_SETTLE_TICKS  = 16'd500;
   localparam logic [15:0] HALF_PERIOD_RST  = 16'd300;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_READ  = 3'd2;
   localparam logic [2:0] CMD_CLAIM = 3'd3;
   localparam logic [2:0] CMD_RAISE = 3'd4;
   localparam logic [2:0] CMD_LOWER = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [1:0] ST_UNCLAIMED = 2'd2;
   localparam logic [1:0] ST_BUSY      = 2'd3;

   typedef struct packed {
      logic is_tick;
      logic is_write;
      logic is_read;
      logic is_claim;
      logic is_cs;
      logic is_raise;
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type cls;
      logic [7:0]    data_byte;
      logic [7:0]    cs_pin;
      logic [1:0]    slot;
      logic          miso_level;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic       mosi;
      logic       sclk;
      logic [3:0] cs_levels;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [1:0] claimed_slot;
      logic [7:0] selected_pin;
      logic [1:0] status;
   } rsp_type;

endpackage

[sv/sms_if.sv]
// ----------------------------------------------------------------------------
// sms_if
// Request, response and register-write channels of the SPI master.
// ----------------------------------------------------------------------------
interface sms_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] data_byte;
   logic [7:0] cs_pin;
   logic [1:0] slot;
   logic       miso_level;

   modport source (output valid, command, data_byte, cs_pin, slot, miso_level,
                   input ready);
   modport sink (input valid, command, data_byte, cs_pin, slot, miso_level,
                 output ready);
endinterface

interface sms_rsp_if;
   logic       valid;
   logic       ready;
   logic       mosi;
   logic       sclk;
   logic [3:0] cs_levels;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic [1:0] claimed_slot;
   logic [7:0] selected_pin;
   logic [1:0] status;

   modport source (output valid, mosi, sclk, cs_levels, busy_res, done_res, read_data,
                   claimed_slot, selected_pin, status, input ready);
   modport sink (input valid, mosi, sclk, cs_levels, busy_res, done_res, read_data,
                 claimed_slot, selected_pin, status, output ready);
endinterface

interface sms_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] half_period_ticks;

   modport source (output valid, half_period_ticks, input ready);
   modport sink (input valid, half_period_ticks, output ready);
endinterface

[sv/sms_front.sv]
// ----------------------------------------------------------------------------
// sms_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sms_front (
   input  logic                    clock,
   input  logic                    reset,
   sms_req_if.sink                 req_chan,
   input  logic                    pop,
   output sms_pkg::queue_head_type head
);

   sms_pkg::queue_entry_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   sms_pkg::queue_entry_type entry;

   always_comb begin
      entry.cls.is_tick  = (req_chan.command == sms_pkg::CMD_TICK);
      entry.cls.is_write = (req_chan.command == sms_pkg::CMD_WRITE);
      entry.cls.is_read  = (req_chan.command == sms_pkg::CMD_READ);
      entry.cls.is_claim = (req_chan.command == sms_pkg::CMD_CLAIM);
      entry.cls.is_cs    = (req_chan.command == sms_pkg::CMD_RAISE) ||
                           (req_chan.command == sms_pkg::CMD_LOWER);
      entry.cls.is_raise = (req_chan.command == sms_pkg::CMD_RAISE);
      entry.data_byte    = req_chan.data_byte;
      entry.cs_pin       = req_chan.cs_pin;
      entry.slot         = req_chan.slot;
      entry.miso_level   = req_chan.miso_level;
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign head.valid     = (count_ff != 2'd0);
   assign head.entry     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

[sv/sms_back.sv]
// ----------------------------------------------------------------------------
// sms_back
// Executes queued requests: bit timing, select slots and the response register.
// ----------------------------------------------------------------------------
module sms_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sms_pkg::queue_head_type head,
   output logic                    pop,
   sms_rsp_if.source               rsp_chan,
   sms_csr_if.sink                 csr_chan
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WLOW  = 3'd1;
   localparam logic [2:0] PH_WHIGH = 3'd2;
   localparam logic [2:0] PH_RLOW  = 3'd3;
   localparam logic [2:0] PH_RH1   = 3'd4;
   localparam logic [2:0] PH_RH2   = 3'd5;
   localparam logic [2:0] PH_RH3   = 3'd6;
   localparam logic [2:0] PH_CS    = 3'd7;

   logic [15:0] half_ff;
   logic [15:0] tick_ff, tick_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        raise_ff, raise_in;
   logic        mosi_ff, mosi_in;
   logic        sclk_ff, sclk_in;
   logic [3:0]  used_ff, used_in;
   logic [3:0]  cs_ff, cs_in;
   logic [7:0]  last_read_ff, last_read_in;
   logic [1:0]  last_claim_ff, last_claim_in;
   logic [1:0]  op_slot_ff, op_slot_in;
   logic [7:0]  pin_mem [4];
   logic        pin_we;
   logic [1:0]  pin_waddr;

   logic              out_valid_ff, out_valid_in;
   sms_pkg::rsp_type  out_ff, out_in;

   sms_pkg::queue_entry_type e;
   logic        busy;
   logic        done;
   logic        cs_item;
   logic        found;
   logic [1:0]  status;
   logic [7:0]  sel_pin;
   logic [15:0] hp;
   logic [16:0] tc;
   logic [3:0]  cs_bit;

   assign csr_chan.ready = 1'b1;
   assign e    = head.entry;
   assign pop  = head.valid && (!out_valid_ff || rsp_chan.ready);
   assign busy = (phase_ff != PH_IDLE);
   assign hp   = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign tc   = {1'b0, tick_ff} + 17'd1;

   always_comb begin
      tick_in       = tick_ff;
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      raise_in      = raise_ff;
      mosi_in       = mosi_ff;
      sclk_in       = sclk_ff;
      used_in       = used_ff;
      cs_in         = cs_ff;
      last_read_in  = last_read_ff;
      last_claim_in = last_claim_ff;
      op_slot_in    = op_slot_ff;
      pin_we        = 1'b0;
      pin_waddr     = 2'd0;
      done          = 1'b0;
      cs_item       = 1'b0;
      found         = 1'b0;
      status        = sms_pkg::ST_OK;
      sel_pin       = 8'd0;
      cs_bit        = 4'd1 << op_slot_ff;

      if (e.cls.is_tick) begin
         if (busy) begin
            if (phase_ff == PH_CS) begin
               cs_item = 1'b1;
               if (tc < {1'b0, sms_pkg::CS_SETTLE_TICKS}) begin
                  tick_in = tc[15:0];
               end else begin
                  tick_in = 16'd0;
                  if (bit_ff == 3'd0) begin
                     cs_in  = raise_ff ? (cs_ff | cs_bit) : (cs_ff & ~cs_bit);
                     bit_in = 3'd1;
                  end else begin
                     phase_in = PH_IDLE;
                     bit_in   = 3'd0;
                     done     = 1'b1;
                  end
               end
            end else if (tc < {1'b0, hp}) begin
               tick_in = tc[15:0];
            end else begin
               tick_in = 16'd0;
               case (phase_ff)
                  PH_WLOW: begin
                     sclk_in  = 1'b1;
                     phase_in = PH_WHIGH;
                  end
                  PH_WHIGH: begin
                     sclk_in = 1'b0;
                     if (bit_ff == 3'd7) begin
                        mosi_in  = 1'b1;
                        phase_in = PH_IDLE;
                        bit_in   = 3'd0;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        shift_in = {shift_ff[6:0], 1'b0};
                        mosi_in  = shift_ff[6];
                        phase_in = PH_WLOW;
                     end
                  end
                  PH_RLOW: begin
                     sclk_in  = 1'b1;
                     phase_in = PH_RH1;
                  end
                  PH_RH1: begin
                     shift_in = {shift_ff[6:0], e.miso_level};
                     phase_in = PH_RH2;
                  end
                  PH_RH2: begin
                     phase_in = PH_RH3;
                  end
                  PH_RH3: begin
                     sclk_in = 1'b0;
                     if (bit_ff == 3'd7) begin
                        last_read_in = shift_ff;
                        phase_in     = PH_IDLE;
                        bit_in       = 3'd0;
                        done         = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_RLOW;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end else if (busy && (e.cls.is_write || e.cls.is_read || e.cls.is_claim ||
                            e.cls.is_cs)) begin
         status = sms_pkg::ST_BUSY;
      end else if (e.cls.is_write) begin
         shift_in = e.data_byte;
         bit_in   = 3'd0;
         tick_in  = 16'd0;
         mosi_in  = e.data_byte[7];
         sclk_in  = 1'b0;
         phase_in = PH_WLOW;
      end else if (e.cls.is_read) begin
         shift_in = 8'd0;
         bit_in   = 3'd0;
         tick_in  = 16'd0;
         sclk_in  = 1'b0;
         phase_in = PH_RLOW;
      end else if (e.cls.is_claim) begin
         for (int i = 0; i < sms_pkg::EFF_SLOTS; i++) begin
            if (!found && !used_ff[i]) begin
               found         = 1'b1;
               used_in[i]    = 1'b1;
               cs_in[i]      = 1'b1;
               pin_we        = 1'b1;
               pin_waddr     = 2'(i);
               last_claim_in = 2'(i);
            end
         end
         if (found) begin
            sel_pin = e.cs_pin;
            done    = 1'b1;
         end else begin
            status = sms_pkg::ST_NO_SLOT;
         end
      end else if (e.cls.is_cs) begin
         if ({1'b0, e.slot} >= 3'(sms_pkg::EFF_SLOTS) || !used_ff[e.slot]) begin
            status = sms_pkg::ST_UNCLAIMED;
         end else begin
            raise_in   = e.cls.is_raise;
            op_slot_in = e.slot;
            tick_in    = 16'd0;
            bit_in     = 3'd0;
            cs_item    = 1'b1;
            if (sms_pkg::CS_SETTLE_TICKS == 16'd0) begin
               cs_bit = 4'd1 << e.slot;
               cs_in  = e.cls.is_raise ? (cs_ff | cs_bit) : (cs_ff & ~cs_bit);
               done   = 1'b1;
            end else begin
               phase_in = PH_CS;
            end
         end
      end

      if (cs_item) begin
         sel_pin = pin_mem[op_slot_in];
      end

      out_in.mosi         = mosi_in;
      out_in.sclk         = sclk_in;
      out_in.cs_levels    = cs_in;
      out_in.busy_res     = (phase_in != PH_IDLE);
      out_in.done_res     = done;
      out_in.read_data    = last_read_in;
      out_in.claimed_slot = last_claim_in;
      out_in.selected_pin = sel_pin;
      out_in.status       = status;

      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff       <= sms_pkg::HALF_PERIOD_RST;
         tick_ff       <= 16'd0;
         phase_ff      <= PH_IDLE;
         bit_ff        <= 3'd0;
         shift_ff      <= 8'd0;
         raise_ff      <= 1'b0;
         mosi_ff       <= 1'b1;
         sclk_ff       <= 1'b0;
         used_ff       <= 4'd0;
         cs_ff         <= 4'hF;
         last_read_ff  <= 8'd0;
         last_claim_ff <= 2'd0;
         op_slot_ff    <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            half_ff <= csr_chan.half_period_ticks;
         end
         if (pop) begin
            tick_ff       <= tick_in;
            phase_ff      <= phase_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            raise_ff      <= raise_in;
            mosi_ff       <= mosi_in;
            sclk_ff       <= sclk_in;
            used_ff       <= used_in;
            cs_ff         <= cs_in;
            last_read_ff  <= last_read_in;
            last_claim_ff <= last_claim_in;
            op_slot_ff    <= op_slot_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pin_we) begin
         pin_mem[pin_waddr] <= e.cs_pin;
      end
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.mosi         = out_ff.mosi;
   assign rsp_chan.sclk         = out_ff.sclk;
   assign rsp_chan.cs_levels    = out_ff.cs_levels;
   assign rsp_chan.busy_res     = out_ff.busy_res;
   assign rsp_chan.done_res     = out_ff.done_res;
   assign rsp_chan.read_data    = out_ff.read_data;
   assign rsp_chan.claimed_slot = out_ff.claimed_slot;
   assign rsp_chan.selected_pin = out_ff.selected_pin;
   assign rsp_chan.status       = out_ff.status;

endmodule

[sv/spi_master_shift_engine.sv]
// ----------------------------------------------------------------------------
// spi_master_shift_engine
// SPI master (mode 0, MSB first) with select slots, advanced by tick requests.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one response per request, in order,
// while the response side is ready. A request enters a two-entry queue; the
// engine executes the queue head and registers the response, so sustained
// throughput is one request per cycle when the response side is ready.
// Each tick request advances the line timing by one tick; a byte transfer or
// select change runs across many tick requests, not across clock cycles.
// Write the half-period register only while no request is queued or waiting
// for its response; the new value applies to the next request executed.
module spi_master_shift_engine (
   input  logic      clock,
   input  logic      reset,
   sms_req_if.sink   req_chan,
   sms_rsp_if.source rsp_chan,
   sms_csr_if.sink   csr_chan
);

   sms_pkg::queue_head_type head;
   logic                    pop;

   sms_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   sms_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

[sv/sms_checker.sv]
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks of the SPI master shift engine.
// ----------------------------------------------------------------------------
module sms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_mosi,
   input logic       rsp_sclk,
   input logic       rsp_busy,
   input logic [1:0] rsp_status
);

   logic [2:0] pending_ff;
   logic       last_busy_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 3'd0;
         last_busy_ff <= 1'b0;
      end else begin
         pending_ff <= pending_ff + 3'(req_acc) - 3'(rsp_acc);
         if (rsp_acc) begin
            last_busy_ff <= rsp_busy;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding request");

   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_status == sms_pkg::ST_BUSY |-> last_busy_ff)
      else $error("busy status while engine was idle");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy |-> rsp_mosi && !rsp_sclk)
      else $error("serial lines not at idle levels");

endmodule

bind spi_master_shift_engine sms_checker u_sms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_mosi   (rsp_chan.mosi),
   .rsp_sclk   (rsp_chan.sclk),
   .rsp_busy   (rsp_chan.busy_res),
   .rsp_status (rsp_chan.status)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the SPI master shift engine. Requests are queued by a
// sequence block and applied by a falling-edge driver in random bursts. A
// request-level model of the engine predicts every response at acceptance.
// The rising-edge monitor compares each response with the oldest
// prediction while the response side stalls on a changing pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CLK_PERIOD = 12;
   localparam int LIMIT_CYCLES = 1_000_000;

   localparam logic [2:0] CMD_RSVD_LO = 3'd6;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;

   localparam int MISO_LOW    = 0;
   localparam int MISO_HIGH   = 1;
   localparam int MISO_RANDOM = 2;

   typedef enum logic [2:0] {
      SP_IDLE, SP_WLOW, SP_WHIGH, SP_RLOW, SP_RH1, SP_RH2, SP_RH3, SP_CS
   } spi_phase_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic [7:0] cs_pin;
      logic [1:0] slot;
      logic       miso_level;
   } spi_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sms_req_if req_chan ();
   sms_rsp_if rsp_chan ();
   sms_csr_if csr_chan ();

   spi_master_shift_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // line model state
   logic [15:0]   eng_half       = sms_pkg::HALF_PERIOD_RST;
   spi_phase_type eng_phase      = SP_IDLE;
   int unsigned   eng_ticks      = 0;
   logic [2:0]    eng_bits       = '0;
   logic [7:0]    eng_shift      = '0;
   logic          eng_raise      = 1'b0;
   logic [1:0]    eng_slot       = '0;
   logic          eng_mosi       = 1'b1;
   logic          eng_sclk       = 1'b0;
   logic [3:0]    eng_cs         = 4'hF;
   logic          eng_used [4]   = '{default: 1'b0};
   logic [7:0]    eng_pin [4]    = '{default: 8'h00};
   logic [7:0]    eng_last_read  = '0;
   logic [1:0]    eng_last_claim = '0;

   spi_req_type       pending_reqs [$];
   sms_pkg::rsp_type  expected_rsps [$];
   int unsigned gen_half_eff = sms_pkg::HALF_PERIOD_RST;
   int          mismatches = 0;

   logic        req_taken  = 1'b0;
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   logic [15:0] stall_pat  = 16'hFFFF;
   logic [3:0]  stall_age  = '0;

   function automatic logic [3:0] cs_after_change();
      logic [3:0] mask;
      mask = 4'b0001 << eng_slot;
      return eng_raise ? (eng_cs | mask) : (eng_cs & ~mask);
   endfunction

   function automatic sms_pkg::rsp_type predict_line_state(spi_req_type r);
      logic [1:0]  status;
      logic        done;
      logic [7:0]  sel_pin;
      logic        cs_item;
      logic        found;
      int unsigned hp;
      int unsigned tc;
      status  = sms_pkg::ST_OK;
      done    = 1'b0;
      sel_pin = '0;
      cs_item = 1'b0;
      found   = 1'b0;
      hp      = (eng_half == 0) ? 1 : eng_half;
      tc      = eng_ticks + 1;
      if (r.command == sms_pkg::CMD_TICK) begin
         if (eng_phase == SP_CS) begin
            cs_item = 1'b1;
            if (tc < sms_pkg::CS_SETTLE_TICKS) begin
               eng_ticks = tc;
            end else begin
               eng_ticks = 0;
               if (eng_bits == 0) begin
                  eng_cs   = cs_after_change();
                  eng_bits = 3'd1;
               end else begin
                  eng_phase = SP_IDLE;
                  eng_bits  = '0;
                  done      = 1'b1;
               end
            end
         end else if (eng_phase != SP_IDLE) begin
            if (tc < hp) begin
               eng_ticks = tc;
            end else begin
               eng_ticks = 0;
               case (eng_phase)
                  SP_WLOW: begin
                     eng_sclk  = 1'b1;
                     eng_phase = SP_WHIGH;
                  end
                  SP_WHIGH: begin
                     eng_sclk = 1'b0;
                     if (eng_bits == 3'd7) begin
                        eng_mosi  = 1'b1;
                        eng_phase = SP_IDLE;
                        eng_bits  = '0;
                        done      = 1'b1;
                     end else begin
                        eng_bits  = eng_bits + 3'd1;
                        eng_shift = eng_shift << 1;
                        eng_mosi  = eng_shift[7];
                        eng_phase = SP_WLOW;
                     end
                  end
                  SP_RLOW: begin
                     eng_sclk  = 1'b1;
                     eng_phase = SP_RH1;
                  end
                  SP_RH1: begin
                     eng_shift = {eng_shift[6:0], r.miso_level};
                     eng_phase = SP_RH2;
                  end
                  SP_RH2: begin
                     eng_phase = SP_RH3;
                  end
                  SP_RH3: begin
                     eng_sclk = 1'b0;
                     if (eng_bits == 3'd7) begin
                        eng_last_read = eng_shift;
                        eng_phase     = SP_IDLE;
                        eng_bits      = '0;
                        done          = 1'b1;
                     end else begin
                        eng_bits  = eng_bits + 3'd1;
                        eng_phase = SP_RLOW;
                     end
                  end
                  default: begin
                     eng_phase = SP_IDLE;
                  end
               endcase
            end
         end
      end else if (r.command <= sms_pkg::CMD_LOWER && eng_phase != SP_IDLE) begin
         status = sms_pkg::ST_BUSY;
      end else if (r.command == sms_pkg::CMD_WRITE) begin
         eng_raise = 1'b0;
         eng_shift = r.data_byte;
         eng_bits  = '0;
         eng_ticks = 0;
         eng_mosi  = r.data_byte[7];
         eng_sclk  = 1'b0;
         eng_phase = SP_WLOW;
      end else if (r.command == sms_pkg::CMD_READ) begin
         eng_shift = '0;
         eng_bits  = '0;
         eng_ticks = 0;
         eng_sclk  = 1'b0;
         eng_phase = SP_RLOW;
      end else if (r.command == sms_pkg::CMD_CLAIM) begin
         for (int i = 0; i < sms_pkg::EFF_SLOTS; i++) begin
            if (!found && !eng_used[i]) begin
               eng_used[i]    = 1'b1;
               eng_pin[i]     = r.cs_pin;
               eng_cs[i]      = 1'b1;
               eng_last_claim = 2'(i);
               sel_pin        = r.cs_pin;
               done           = 1'b1;
               found          = 1'b1;
            end
         end
         if (!found) status = sms_pkg::ST_NO_SLOT;
      end else if (r.command == sms_pkg::CMD_RAISE || r.command == sms_pkg::CMD_LOWER) begin
         if (r.slot >= sms_pkg::EFF_SLOTS || !eng_used[r.slot]) begin
            status = sms_pkg::ST_UNCLAIMED;
         end else begin
            eng_raise = (r.command == sms_pkg::CMD_RAISE);
            eng_slot  = r.slot;
            eng_ticks = 0;
            eng_bits  = '0;
            cs_item   = 1'b1;
            if (sms_pkg::CS_SETTLE_TICKS == 0) begin
               eng_cs = cs_after_change();
               done   = 1'b1;
            end else begin
               eng_phase = SP_CS;
            end
         end
      end

      if (cs_item) sel_pin = eng_pin[eng_slot];

      return '{mosi: eng_mosi, sclk: eng_sclk, cs_levels: eng_cs,
               busy_res: (eng_phase != SP_IDLE), done_res: done,
               read_data: eng_last_read, claimed_slot: eng_last_claim,
               selected_pin: sel_pin, status: status};
   endfunction

   task automatic report_mismatch(string what, sms_pkg::rsp_type want,
                                  sms_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected %p, got %p", $realtime, what, want, got);
   endtask

   // request driver
   always @(negedge clock) begin
      spi_req_type nxt;
      logic        v;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         v = 1'b0;
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            v   = 1'b1;
            req_chan.command    <= nxt.command;
            req_chan.data_byte  <= nxt.data_byte;
            req_chan.cs_pin     <= nxt.cs_pin;
            req_chan.slot       <= nxt.slot;
            req_chan.miso_level <= nxt.miso_level;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 30);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
         req_chan.valid <= v;
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      logic [15:0] pat;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         pat = stall_pat;
         if (stall_age == 0) begin
            case ($urandom_range(0, 3))
               0: pat = 16'hFFFF;
               1: pat = 16'($urandom);
               2: pat = 16'($urandom) | 16'($urandom) | 16'($urandom);
               default: pat = 16'hFF00;
            endcase
         end
         stall_pat      <= pat;
         rsp_chan.ready <= pat[stall_age];
         stall_age      <= stall_age + 4'd1;
      end
   end

   // prediction and response check
   always @(posedge clock) begin
      sms_pkg::rsp_type got;
      sms_pkg::rsp_type want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) eng_half = csr_chan.half_period_ticks;
         if (req_chan.valid && req_chan.ready)
            expected_rsps.push_back(predict_line_state('{
               command: req_chan.command, data_byte: req_chan.data_byte,
               cs_pin: req_chan.cs_pin, slot: req_chan.slot,
               miso_level: req_chan.miso_level}));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{mosi: rsp_chan.mosi, sclk: rsp_chan.sclk,
                    cs_levels: rsp_chan.cs_levels, busy_res: rsp_chan.busy_res,
                    done_res: rsp_chan.done_res, read_data: rsp_chan.read_data,
                    claimed_slot: rsp_chan.claimed_slot,
                    selected_pin: rsp_chan.selected_pin, status: rsp_chan.status};
            if (expected_rsps.size() == 0) begin
               report_mismatch("response without request", '0, got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) report_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   task automatic push_req(logic [2:0] cmd, logic [7:0] arg);
      spi_req_type r;
      r.command    = cmd;
      r.data_byte  = 8'($urandom);
      r.cs_pin     = 8'($urandom);
      r.slot       = 2'($urandom);
      r.miso_level = 1'($urandom);
      case (cmd)
         sms_pkg::CMD_TICK:  r.miso_level = arg[0];
         sms_pkg::CMD_WRITE: r.data_byte  = arg;
         sms_pkg::CMD_CLAIM: r.cs_pin     = arg;
         sms_pkg::CMD_RAISE, sms_pkg::CMD_LOWER: r.slot = arg[1:0];
         default: ;
      endcase
      pending_reqs.push_back(r);
   endtask

   // ticks, with rejected or ignored requests mixed in when noisy
   task automatic push_ticks(int unsigned n, int miso_mode, bit noisy);
      for (int unsigned k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            push_req(3'($urandom_range(1, 7)), 8'($urandom));
         push_req(sms_pkg::CMD_TICK,
                  (miso_mode == MISO_RANDOM) ? 8'($urandom) : 8'(miso_mode));
      end
   endtask

   task automatic send_byte(logic [7:0] data, bit noisy);
      push_req(sms_pkg::CMD_WRITE, data);
      push_ticks(16 * gen_half_eff, MISO_RANDOM, noisy);
   endtask

   task automatic fetch_byte(int miso_mode, bit noisy);
      push_req(sms_pkg::CMD_READ, 8'($urandom));
      push_ticks(32 * gen_half_eff, miso_mode, noisy);
   endtask

   task automatic change_select(logic [2:0] cmd, logic [1:0] slot, bit noisy);
      push_req(cmd, {6'd0, slot});
      push_ticks(2 * sms_pkg::CS_SETTLE_TICKS, MISO_RANDOM, noisy);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0);
   endtask

   task automatic write_half_period(logic [15:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_chan.half_period_ticks <= value;
      csr_chan.valid             <= 1'b1;
      do @(posedge clock);
      while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      gen_half_eff = (value == 0) ? 1 : value;
   endtask

   task automatic random_phase(int unsigned budget);
      int unsigned made;
      int unsigned pick;
      int unsigned n;
      made = 0;
      while (made < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_byte(8'($urandom), 1'($urandom));
            made += 1 + 16 * gen_half_eff;
         end else if (pick < 68) begin
            fetch_byte(MISO_RANDOM, 1'($urandom));
            made += 1 + 32 * gen_half_eff;
         end else if (pick < 76) begin
            push_req(sms_pkg::CMD_CLAIM, 8'($urandom));
            made += 1;
         end else if (pick < 88) begin
            n = $urandom_range(1, 4);
            push_ticks(n, MISO_RANDOM, 1'b0);
            made += n;
         end else if (pick < 97) begin
            push_req($urandom_range(0, 1) ? CMD_RSVD_LO : CMD_RSVD_HI, 8'($urandom));
            made += 1;
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin
      req_chan.valid             = 1'b0;
      req_chan.command           = sms_pkg::CMD_TICK;
      req_chan.data_byte         = '0;
      req_chan.cs_pin            = '0;
      req_chan.slot              = '0;
      req_chan.miso_level        = 1'b0;
      rsp_chan.ready             = 1'b0;
      csr_chan.valid             = 1'b0;
      csr_chan.half_period_ticks = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle behavior and select slots at the reset half-period
      push_req(sms_pkg::CMD_TICK, 8'd0);
      push_req(sms_pkg::CMD_TICK, 8'd1);
      push_req(CMD_RSVD_LO, 8'($urandom));
      push_req(CMD_RSVD_HI, 8'($urandom));
      push_req(sms_pkg::CMD_RAISE, 8'd0);
      push_req(sms_pkg::CMD_LOWER, 8'd1);
      push_req(sms_pkg::CMD_CLAIM, 8'h00);
      push_req(sms_pkg::CMD_RAISE, 8'd3);
      push_req(sms_pkg::CMD_CLAIM, 8'hFF);
      push_req(sms_pkg::CMD_CLAIM, 8'hA5);
      push_req(sms_pkg::CMD_CLAIM, 8'h5A);
      push_req(sms_pkg::CMD_CLAIM, 8'h3C);
      change_select(sms_pkg::CMD_LOWER, 2'd1, 1'b1);

      // byte transfers at the shortest half-period
      write_half_period(16'd1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      fetch_byte(MISO_HIGH, 1'b0);
      fetch_byte(MISO_LOW, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);

      // zero half-period acts as one
      write_half_period(16'd0);
      send_byte(8'hA5, 1'b1);
      fetch_byte(MISO_RANDOM, 1'b0);

      for (int p = 0; p < 3; p++) begin
         write_half_period((p == 1) ? 16'd0 : 16'($urandom_range(1, 3)));
         random_phase(80);
      end

      // longest half-period: a write that never reaches its first edge
      write_half_period(16'hFFFF);
      push_req(sms_pkg::CMD_WRITE, 8'($urandom));
      push_ticks(100, MISO_RANDOM, 1'b0);
      push_ticks(40, MISO_RANDOM, 1'b1);

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
sv/sms_pkg.sv
sv/sms_if.sv
sv/sms_front.sv
sv/sms_back.sv
sv/spi_master_shift_engine.sv
sv/sms_checker.sv
tb/sv/tb.sv
